// ===== rtl/rlcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rlcr_pkg
// Shared types and codes for the RGB LED chain refresh block: action codes,
// packet modes, register indexes and the colour entry layout.
// ----------------------------------------------------------------------------
package rlcr_pkg;

  // input actions
  localparam logic [1:0] ACT_SET     = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;

  // result kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  // packet modes
  localparam logic [1:0] MODE_PWM = 2'b00;
  localparam logic [1:0] MODE_CUR = 2'b01;

  // configuration register indexes
  localparam logic [1:0] CFG_CUR_RED   = 2'd0;
  localparam logic [1:0] CFG_CUR_GREEN = 2'd1;
  localparam logic [1:0] CFG_CUR_BLUE  = 2'd2;

  // current register reset values
  localparam logic [6:0] RST_CUR_RED   = 7'd120;
  localparam logic [6:0] RST_CUR_GREEN = 7'd100;
  localparam logic [6:0] RST_CUR_BLUE  = 7'd100;

  localparam int unsigned COL_W = 10;
  localparam int unsigned CUR_W = 7;

  // one store entry, holding the values as the caller gave them
  typedef struct packed {
    logic [COL_W-1:0] blue;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
  } colour_t;

  // current-control register set
  typedef struct packed {
    logic [CUR_W-1:0] blue;
    logic [CUR_W-1:0] green;
    logic [CUR_W-1:0] red;
  } cur_t;

  // store access strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

// ===== rtl/rlcr_store.sv =====
// ----------------------------------------------------------------------------
// rlcr_store
// Colour store: one synchronous memory with a registered read port and one
// valid flag per entry, so that reset clears every entry at once.
// ----------------------------------------------------------------------------
module rlcr_store
  import rlcr_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  store_ctl_t    ctl,
  input  logic [AW-1:0] wr_addr,
  input  colour_t       wr_data,
  input  logic [AW-1:0] rd_addr,
  output colour_t       rd_data
);

  colour_t          mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  colour_t          rd_q_r;
  logic             rd_vld_r;

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // mark written entries, clear all at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q_r   <= mem_r[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // entries never written read as zero
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== rtl/rlcr_cfg.sv =====
// ----------------------------------------------------------------------------
// rlcr_cfg
// Current-control registers, written through the plain write port.
// ----------------------------------------------------------------------------
module rlcr_cfg
  import rlcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CUR_W-1:0] cfg_wdata,
  output cur_t             cur
);

  cur_t cur_r;

  // decode the index, drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.red   <= RST_CUR_RED;
      cur_r.green <= RST_CUR_GREEN;
      cur_r.blue  <= RST_CUR_BLUE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUR_RED:   cur_r.red   <= cfg_wdata;
        CFG_CUR_GREEN: cur_r.green <= cfg_wdata;
        CFG_CUR_BLUE:  cur_r.blue  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cur = cur_r;

endmodule

// ===== rtl/rlcr_seq.sv =====
// ----------------------------------------------------------------------------
// rlcr_seq
// Action sequencer: decodes input words, drives the store ports, walks the
// store for a refresh and holds the result word in an output register.
// ----------------------------------------------------------------------------
module rlcr_seq
  import rlcr_pkg::*;
#(
  parameter int unsigned LED_COUNT = 8,
  parameter int unsigned AW        = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  // input word
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_action,
  input  logic [2:0]       in_led_index,
  input  colour_t          in_colour,
  // registers
  input  cur_t             cur,
  // store
  output store_ctl_t       st_ctl,
  output logic [AW-1:0]    st_waddr,
  output colour_t          st_wdata,
  output logic [AW-1:0]    st_raddr,
  input  colour_t          st_rdata,
  // result word
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic             out_kind,
  output logic [31:0]      out_word,
  output logic             out_blank,
  output logic             out_latch,
  output colour_t          out_colour,
  output logic             out_last
);

  localparam logic [AW-1:0] LAST_IDX = AW'(LED_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_PWM  = 4'b0100,
    ST_CUR  = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_oor_r, rd_oor_nxt;

  logic          out_vld_r, out_vld_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [31:0]   out_word_r, out_word_nxt;
  logic          out_blank_r, out_blank_nxt;
  logic          out_latch_r, out_latch_nxt;
  colour_t       out_col_r, out_col_nxt;
  logic          out_last_r, out_last_nxt;

  logic          out_free;
  logic          in_acc;
  logic [5:0]    idx_ext;
  logic          in_range;
  logic          pwm_issue;
  logic          ld;

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // range check of the requested entry
  assign idx_ext  = {3'b000, in_led_index};
  assign in_range = idx_ext < 6'(LED_COUNT);

  // one store read per PWM packet, issued once the output slot drains
  assign pwm_issue = (state_r == ST_PWM) && !rd_pend_r && out_free;

  // store ports; a refresh never overlaps a write, so no forwarding is needed
  assign st_ctl.wr_en = in_acc && (in_action == ACT_SET) && in_range;
  assign st_ctl.rd_en = (in_acc && (in_action == ACT_READ) && in_range) || pwm_issue;
  assign st_waddr     = idx_ext[AW-1:0];
  assign st_wdata     = in_colour;
  assign st_raddr     = (state_r == ST_PWM) ? cnt_r : idx_ext[AW-1:0];

  // sequence control and result formation
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = rd_pend_r;
    rd_oor_nxt    = rd_oor_r;
    ld            = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_word_nxt  = out_word_r;
    out_blank_nxt = out_blank_r;
    out_latch_nxt = out_latch_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_READ: begin
              state_nxt  = ST_RD;
              rd_oor_nxt = !in_range;
            end
            ACT_REFRESH: begin
              state_nxt   = ST_PWM;
              cnt_nxt     = '0;
              rd_pend_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        // read data is back, the output slot is free here
        ld            = 1'b1;
        out_kind_nxt  = KIND_REPLY;
        out_word_nxt  = '0;
        out_blank_nxt = 1'b0;
        out_latch_nxt = 1'b0;
        out_col_nxt   = rd_oor_r ? '0 : st_rdata;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_PWM: begin
        if (pwm_issue) begin
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          // red field carries the green slot, green field the red slot
          ld            = 1'b1;
          rd_pend_nxt   = 1'b0;
          out_kind_nxt  = KIND_PACKET;
          out_word_nxt  = {MODE_PWM, st_rdata.blue, st_rdata.green, st_rdata.red};
          out_blank_nxt = (cnt_r == '0);
          out_latch_nxt = (cnt_r == LAST_IDX);
          out_col_nxt   = '0;
          out_last_nxt  = 1'b0;
          if (cnt_r == LAST_IDX) begin
            cnt_nxt   = '0;
            state_nxt = ST_CUR;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_CUR: begin
        if (out_free) begin
          ld            = 1'b1;
          out_kind_nxt  = KIND_PACKET;
          out_word_nxt  = {MODE_CUR, 3'b000, cur.blue, 3'b000, cur.red,
                           3'b000, cur.green};
          out_blank_nxt = 1'b0;
          out_latch_nxt = (cnt_r == LAST_IDX);
          out_col_nxt   = '0;
          out_last_nxt  = (cnt_r == LAST_IDX);
          if (cnt_r == LAST_IDX) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ld) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_oor_r    <= rd_oor_nxt;
    out_kind_r  <= out_kind_nxt;
    out_word_r  <= out_word_nxt;
    out_blank_r <= out_blank_nxt;
    out_latch_r <= out_latch_nxt;
    out_col_r   <= out_col_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_kind   = out_kind_r;
  assign out_word   = out_word_r;
  assign out_blank  = out_blank_r;
  assign out_latch  = out_latch_r;
  assign out_colour = out_col_r;
  assign out_last   = out_last_r;

  // a pending read reply always finds the output slot empty
  a_rd_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> !out_vld_r)
    else $error("read reply would overwrite a waiting word");

  // a returning PWM read always finds the output slot empty
  a_pwm_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_vld_r)
    else $error("PWM packet would overwrite a waiting word");

  // the walk counter stays inside the chain
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_IDX)
    else $error("walk counter beyond last LED");

  // a final word is a read reply or a latched packet
  a_last_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_last_r) |-> (out_kind_r == KIND_REPLY || out_latch_r))
    else $error("final word without latch");

  // no input is taken while a refresh is in progress
  a_no_acc_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PWM || state_r == ST_CUR) |-> !in_acc)
    else $error("input accepted during refresh");

endmodule

// ===== rtl/rgb_led_chain_refresh.sv =====
// ----------------------------------------------------------------------------
// rgb_led_chain_refresh
// Driver core for a chain of RGB LED controllers with a per-LED colour store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per action. in_tuser carries the action (set, read,
//           refresh); in_tdata carries the LED index and the colour.
//   out_* : result words. A read gives one reply (tuser kind = 1). A refresh
//           gives LED_COUNT PWM packets then LED_COUNT current packets, with
//           blank on the first PWM packet, latch on the last of each phase,
//           tlast on the final one.
//   cfg_* : current-control registers, written only while idle by the
//           user; the block itself does not enforce this.
// Actions: a set or an undefined action gives nothing. A read goes
//   through the registered store read port, its reply registered. In a
//   refresh each PWM packet costs a store read plus a load of the output
//   register, each current packet a load of the output register only.
// Reset clears the whole store at once through per-entry valid flags; no
//   clearing pass. When the receiver stalls, the output register holds and
//   the walk pauses; a new word is taken when idle and the slot drains.
// ----------------------------------------------------------------------------
module rgb_led_chain_refresh
  import rlcr_pkg::*;
#(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input: tdata = led_index[2:0], red_in[12:3], green_in[22:13],
  //        blue_in[32:23], zero fill; tuser = action[1:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  // output: tdata = packet_word[31:0], red_out[41:32], green_out[51:42],
  //         blue_out[61:52], zero fill; tuser = kind[0], blank_before[1],
  //         latch_after[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  localparam int unsigned AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  cur_t          cur;
  store_ctl_t    st_ctl;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] st_raddr;
  colour_t       st_wdata;
  colour_t       st_rdata;
  colour_t       in_colour;
  colour_t       out_colour;
  logic          out_kind;
  logic [31:0]   out_word;
  logic          out_blank;
  logic          out_latch;

  // unpack the input word
  assign in_colour.red   = in_tdata[12:3];
  assign in_colour.green = in_tdata[22:13];
  assign in_colour.blue  = in_tdata[32:23];

  rlcr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cur       (cur)
  );

  rlcr_store #(
    .DEPTH (LED_COUNT),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  rlcr_seq #(
    .LED_COUNT (LED_COUNT),
    .AW        (AW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_action    (in_tuser),
    .in_led_index (in_tdata[2:0]),
    .in_colour    (in_colour),
    .cur          (cur),
    .st_ctl       (st_ctl),
    .st_waddr     (st_waddr),
    .st_wdata     (st_wdata),
    .st_raddr     (st_raddr),
    .st_rdata     (st_rdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_kind     (out_kind),
    .out_word     (out_word),
    .out_blank    (out_blank),
    .out_latch    (out_latch),
    .out_colour   (out_colour),
    .out_last     (out_tlast)
  );

  // pack the result word
  assign out_tdata = {2'b00, out_colour.blue, out_colour.green, out_colour.red, out_word};
  assign out_tuser = {out_latch, out_blank, out_kind};

endmodule

// ===== tb/rgb_led_chain_refresh_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_led_chain_refresh_tb
// Self-checking bench for the RGB LED chain refresh block. Drives set, read,
// refresh and undefined action words with random gaps and random receiver
// stalls. Keeps its own copy of the colour store and current registers and
// checks every result word, field by field, in order.
// ----------------------------------------------------------------------------
module rgb_led_chain_refresh_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlcr_pkg::*;

  localparam int unsigned LED_COUNT      = 8;
  localparam int unsigned DRAIN_CYCLES   = 3 * LED_COUNT + 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_IDLE       = 18;

  // action code with no defined meaning, must be ignored
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  // expected fields of one result word
  typedef struct {
    logic        kind;
    logic [31:0] packet;
    logic        blank;
    logic        latch;
    logic [9:0]  red;
    logic [9:0]  green;
    logic [9:0]  blue;
    logic        last;
  } chain_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = ACT_SET;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_CUR_RED;
  logic [6:0]  cfg_wdata = '0;

  // mirror of the block state
  colour_t       led_colour [LED_COUNT];
  cur_t          led_current;
  chain_result_t expected_results [$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold;
  int idle_cycles;
  int mismatches;
  int words_sent;
  int refreshes_sent;
  int results_checked;

  rgb_led_chain_refresh #(
    .LED_COUNT(LED_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction and checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_result(logic kind, logic [31:0] packet, logic blank,
                              logic latch, colour_t colour, logic last);
    chain_result_t res;
    res.kind   = kind;
    res.packet = packet;
    res.blank  = blank;
    res.latch  = latch;
    res.red    = colour.red;
    res.green  = colour.green;
    res.blue   = colour.blue;
    res.last   = last;
    expected_results.push_back(res);
  endtask

  // work out the results of one accepted action word
  task automatic predict_action(logic [1:0] action, logic [39:0] data);
    logic [2:0] idx;
    colour_t    entry;
    colour_t    none;
    idx      = data[2:0];
    entry    = {data[32:23], data[12:3], data[22:13]};
    none     = '0;
    case (action)
      ACT_SET: begin
        if (idx < LED_COUNT) led_colour[idx] = entry;
      end
      ACT_READ: begin
        queue_result(KIND_REPLY, 32'd0, 1'b0, 1'b0,
                     (idx < LED_COUNT) ? led_colour[idx] : none, 1'b1);
      end
      ACT_REFRESH: begin
        // PWM phase: green sits in the red field, red in the green field
        for (int i = 0; i < LED_COUNT; i++) begin
          queue_result(KIND_PACKET,
                       {MODE_PWM, led_colour[i].blue, led_colour[i].green,
                        led_colour[i].red},
                       i == 0, i == LED_COUNT - 1, none, 1'b0);
        end
        // current-control phase
        for (int i = 0; i < LED_COUNT; i++) begin
          queue_result(KIND_PACKET,
                       {MODE_CUR, 3'b000, led_current.blue, 3'b000, led_current.red,
                        3'b000, led_current.green},
                       1'b0, i == LED_COUNT - 1, none, i == LED_COUNT - 1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    chain_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual data %0h user %0h last %0b",
               $time, out_tdata, out_tuser, out_tlast);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(out_tuser[0]));
      check_field("packet_word", want.packet, out_tdata[31:0]);
      check_field("blank_before", 32'(want.blank), 32'(out_tuser[1]));
      check_field("latch_after", 32'(want.latch), 32'(out_tuser[2]));
      check_field("red_out", 32'(want.red), 32'(out_tdata[41:32]));
      check_field("green_out", 32'(want.green), 32'(out_tdata[51:42]));
      check_field("blue_out", 32'(want.blue), 32'(out_tdata[61:52]));
      check_field("last", 32'(want.last), 32'(out_tlast));
    end
    results_checked++;
  endtask

  // sample both channels and the register port at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) led_colour[i] = '0;
      led_current.red   = RST_CUR_RED;
      led_current.green = RST_CUR_GREEN;
      led_current.blue  = RST_CUR_BLUE;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) predict_action(in_tuser, in_tdata);
      if (cfg_we) begin
        case (cfg_index)
          CFG_CUR_RED:   led_current.red   = cfg_wdata;
          CFG_CUR_GREEN: led_current.green = cfg_wdata;
          CFG_CUR_BLUE:  led_current.blue  = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // receiver: with rx_idle set, stall randomly after each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else if (out_tready && out_tvalid) begin
      rx_hold = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      out_tready <= (rx_hold == 0);
    end else if (!out_tready) begin
      if (rx_hold > 1) begin
        rx_hold--;
      end else begin
        rx_hold = 0;
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("rgb_led_chain_refresh test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // send one action word and hold it until accepted
  task automatic send_action(logic [1:0] action, logic [2:0] idx,
                             logic [9:0] red, logic [9:0] green, logic [9:0] blue);
    int gap;
    gap = (!tx_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {7'd0, blue, green, red, idx};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (action == ACT_REFRESH) refreshes_sent++;
  endtask

  // drop valid and wait until every expected word is back and the block is idle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three current registers back to back
  task automatic set_currents(logic [6:0] red, logic [6:0] green, logic [6:0] blue);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CUR_RED;
    cfg_wdata <= red;
    @(posedge clk);
    cfg_index <= CFG_CUR_GREEN;
    cfg_wdata <= green;
    @(posedge clk);
    cfg_index <= CFG_CUR_BLUE;
    cfg_wdata <= blue;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // store must read back zero and refresh must carry the reset currents
  task automatic test_reset_state();
    send_action(ACT_READ, 3'd0, 10'd0, 10'd0, 10'd0);
    send_action(ACT_READ, 3'd7, 10'h3FF, 10'h3FF, 10'h3FF);
    send_action(ACT_REFRESH, 3'd0, 10'd0, 10'd0, 10'd0);
  endtask

  // extreme colours, red/green swap on the chain, undefined action ignored
  task automatic test_colour_extremes();
    send_action(ACT_SET, 3'd0, 10'h3FF, 10'h3FF, 10'h3FF);
    send_action(ACT_SET, 3'd7, 10'h3FF, 10'h000, 10'h000);
    send_action(ACT_SET, 3'd3, 10'h155, 10'h2AA, 10'h3FF);
    send_action(ACT_SET, 3'd5, 10'h2AA, 10'h155, 10'h000);
    send_action(ACT_READ, 3'd0, 10'd0, 10'd0, 10'd0);
    send_action(ACT_READ, 3'd7, 10'd0, 10'd0, 10'd0);
    send_action(ACT_READ, 3'd3, 10'd0, 10'd0, 10'd0);
    send_action(ACT_READ, 3'd5, 10'd0, 10'd0, 10'd0);
    send_action(ACT_UNDEF, 3'd2, 10'h3FF, 10'h3FF, 10'h3FF);
    send_action(ACT_READ, 3'd2, 10'd0, 10'd0, 10'd0);
    send_action(ACT_REFRESH, 3'd7, 10'h3FF, 10'h3FF, 10'h3FF);
  endtask

  // current registers at their extremes and one mixed setting
  task automatic test_current_extremes();
    wait_drained();
    set_currents(7'd127, 7'd127, 7'd127);
    send_action(ACT_REFRESH, 3'd1, 10'd0, 10'd0, 10'd0);
    wait_drained();
    set_currents(7'd0, 7'd0, 7'd0);
    send_action(ACT_REFRESH, 3'd2, 10'd0, 10'd0, 10'd0);
    wait_drained();
    set_currents(7'd127, 7'd0, 7'd85);
    send_action(ACT_REFRESH, 3'd4, 10'd0, 10'd0, 10'd0);
  endtask

  // random mix of actions; refresh less often since it yields many words
  task automatic test_random_traffic(int count);
    int         pick;
    logic [1:0] action;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      action = ACT_SET;
      else if (pick < 80) action = ACT_READ;
      else if (pick < 92) action = ACT_REFRESH;
      else                action = ACT_UNDEF;
      send_action(action, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_colour_extremes();
    test_current_extremes();

    // random phases, each with its own currents and idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      set_currents(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
      tx_idle = (phase == 0 || phase == 2);
      rx_idle = (phase == 0 || phase == 3);
      test_random_traffic(78);
    end

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    wait_drained();

    $display("Covered set, read, refresh and undefined actions under random gaps and stalls;");
    $display("%0d words sent (%0d refreshes), %0d results checked, %0d mismatches",
             words_sent, refreshes_sent, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("rgb_led_chain_refresh test passed");
    end else begin
      $display("rgb_led_chain_refresh test failed");
    end
    $finish;
  end

endmodule
